// File: rtl/core/rc4_drop256_stream_cipher_unit_macros.svh
// Assertion macros shared by the RC4 drop-256 cipher RTL.
// Needs i_clk and i_rst_n in the scope of every module that uses them.
`ifndef RC4_DROP256_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_DROP256_STREAM_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RC4D_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
`define RC4D_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define RC4D_ASSERT(lbl, expr, msg)
`define RC4D_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/core/rc4d_pkg.sv
// Package for the RC4 drop-256 cipher: sizes, control word types and the
// microcode table. No dependencies.
`default_nettype none

package rc4d_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int MAX_KEY_BYTES = 256;
    localparam int KCNT_W        = 9;
    localparam int PC_W          = 5;

    localparam logic [7:0] CNT_LAST = 8'(TABLE_DEPTH - 1);
    localparam logic [KCNT_W-1:0] KEY_LIMIT = KCNT_W'(MAX_KEY_BYTES);

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    // Microcode addresses.
    localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] PC_FILL     = 5'd1;
    localparam logic [PC_W-1:0] PC_KSA_RD_I = 5'd2;
    localparam logic [PC_W-1:0] PC_KSA_ADD  = 5'd3;
    localparam logic [PC_W-1:0] PC_KSA_RD_J = 5'd4;
    localparam logic [PC_W-1:0] PC_KSA_WR_J = 5'd5;
    localparam logic [PC_W-1:0] PC_KSA_WR_I = 5'd6;
    localparam logic [PC_W-1:0] PC_KSA_END  = 5'd7;
    localparam logic [PC_W-1:0] PC_DRP_RD_I = 5'd8;
    localparam logic [PC_W-1:0] PC_DRP_ADD  = 5'd9;
    localparam logic [PC_W-1:0] PC_DRP_RD_J = 5'd10;
    localparam logic [PC_W-1:0] PC_DRP_WR_J = 5'd11;
    localparam logic [PC_W-1:0] PC_DRP_WR_I = 5'd12;
    localparam logic [PC_W-1:0] PC_DRP_END  = 5'd13;
    localparam logic [PC_W-1:0] PC_DAT_RD_I = 5'd14;
    localparam logic [PC_W-1:0] PC_DAT_ADD  = 5'd15;
    localparam logic [PC_W-1:0] PC_DAT_RD_J = 5'd16;
    localparam logic [PC_W-1:0] PC_DAT_WR_J = 5'd17;
    localparam logic [PC_W-1:0] PC_DAT_WR_I = 5'd18;
    localparam logic [PC_W-1:0] PC_DAT_RD_T = 5'd19;
    localparam logic [PC_W-1:0] PC_DAT_OUT  = 5'd20;
    localparam logic [PC_W-1:0] PC_LAST     = PC_DAT_OUT;

    typedef enum logic [2:0] {
        ADDR_CNT, ADDR_I, ADDR_I_INC, ADDR_J, ADDR_T
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_CNT, WD_SI, WD_SJ
    } t_wd_sel;

    typedef enum logic [1:0] {
        I_HOLD, I_INC, I_CLR
    } t_i_op;

    typedef enum logic [1:0] {
        J_HOLD, J_CLR, J_ADD_SI, J_ADD_KEY
    } t_j_op;

    typedef enum logic [1:0] {
        K_HOLD, K_STEP, K_CLR
    } t_k_op;

    typedef enum logic [2:0] {
        COND_NEXT, COND_ALWAYS, COND_LOOP, COND_DISPATCH, COND_WAIT_OUT
    } t_cond;

    typedef struct packed {
        t_addr_sel        addr_sel;
        logic             s_we;
        t_wd_sel          wd_sel;
        logic             ld_si;
        logic             ld_sj;
        t_i_op            i_op;
        t_j_op            j_op;
        t_k_op            k_op;
        logic             cnt_inc;
        logic             set_keyed;
        logic             clr_count;
        logic             out_load;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctl;

    typedef struct packed {
        logic accept;
        logic mode;
        logic last;
        logic out_free;
        logic cnt_last;
    } t_seq_in;

    localparam t_ctl CTL_NOP = '{
        addr_sel:  ADDR_I,
        s_we:      1'b0,
        wd_sel:    WD_SI,
        ld_si:     1'b0,
        ld_sj:     1'b0,
        i_op:      I_HOLD,
        j_op:      J_HOLD,
        k_op:      K_HOLD,
        cnt_inc:   1'b0,
        set_keyed: 1'b0,
        clr_count: 1'b0,
        out_load:  1'b0,
        cond:      COND_NEXT,
        target:    PC_IDLE
    };

    // Control store. The permutation RAM has one port with registered read
    // data, so every read is issued in the step before its data is used.
    function automatic t_ctl rom_word(input logic [PC_W-1:0] pc);
        t_ctl w;
        w = CTL_NOP;
        case (pc)
            PC_IDLE: begin
                w.cond = COND_DISPATCH;
            end
            PC_FILL: begin
                w.addr_sel  = ADDR_CNT;
                w.s_we      = 1'b1;
                w.wd_sel    = WD_CNT;
                w.cnt_inc   = 1'b1;
                w.set_keyed = 1'b1;
                w.i_op      = I_CLR;
                w.j_op      = J_CLR;
                w.k_op      = K_CLR;
                w.cond      = COND_LOOP;
                w.target    = PC_FILL;
            end
            PC_KSA_RD_I, PC_DAT_WR_I: begin
                if (pc == PC_DAT_WR_I) begin
                    w.s_we   = 1'b1;
                    w.wd_sel = WD_SJ;
                end
                w.addr_sel = ADDR_I;
            end
            PC_KSA_ADD: begin
                w.ld_si = 1'b1;
                w.j_op  = J_ADD_KEY;
            end
            PC_KSA_RD_J, PC_DRP_RD_J, PC_DAT_RD_J: begin
                w.addr_sel = ADDR_J;
            end
            PC_KSA_WR_J, PC_DRP_WR_J, PC_DAT_WR_J: begin
                w.ld_sj    = 1'b1;
                w.addr_sel = ADDR_J;
                w.s_we     = 1'b1;
                w.wd_sel   = WD_SI;
            end
            PC_KSA_WR_I: begin
                w.addr_sel = ADDR_I;
                w.s_we     = 1'b1;
                w.wd_sel   = WD_SJ;
                w.i_op     = I_INC;
                w.k_op     = K_STEP;
                w.cnt_inc  = 1'b1;
                w.cond     = COND_LOOP;
                w.target   = PC_KSA_RD_I;
            end
            PC_KSA_END: begin
                w.j_op = J_CLR;
            end
            PC_DRP_RD_I, PC_DAT_RD_I: begin
                w.addr_sel = ADDR_I_INC;
                w.i_op     = I_INC;
            end
            PC_DRP_ADD, PC_DAT_ADD: begin
                w.ld_si = 1'b1;
                w.j_op  = J_ADD_SI;
            end
            PC_DRP_WR_I: begin
                w.addr_sel = ADDR_I;
                w.s_we     = 1'b1;
                w.wd_sel   = WD_SJ;
                w.cnt_inc  = 1'b1;
                w.cond     = COND_LOOP;
                w.target   = PC_DRP_RD_I;
            end
            PC_DRP_END: begin
                w.clr_count = 1'b1;
                w.k_op      = K_CLR;
                w.cond      = COND_ALWAYS;
                w.target    = PC_IDLE;
            end
            PC_DAT_RD_T: begin
                w.addr_sel = ADDR_T;
            end
            PC_DAT_OUT: begin
                // Keep reading the same entry so the data holds while stalled.
                w.addr_sel = ADDR_T;
                w.out_load = 1'b1;
                w.cond     = COND_WAIT_OUT;
                w.target   = PC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rc4d_ram.sv
// Generic single-port RAM with registered read data (read before write).
// No dependencies.
`default_nettype none

module rc4d_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/rc4d_seq.sv
// Microcode sequencer: program counter, control store lookup and branch logic.
// Depends on rc4d_pkg and the assertion macro header.
`default_nettype none
`include "rc4_drop256_stream_cipher_unit_macros.svh"

module rc4d_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rc4d_pkg::t_seq_in i_stat,
    output rc4d_pkg::t_ctl       o_ctl,
    output logic                 o_idle
);

    logic [rc4d_pkg::PC_W-1:0] r_pc;
    logic [rc4d_pkg::PC_W-1:0] n_pc;
    rc4d_pkg::t_ctl            ctl;

    assign ctl    = rc4d_pkg::rom_word(r_pc);
    assign o_ctl  = ctl;
    assign o_idle = (r_pc == rc4d_pkg::PC_IDLE);

    always_comb begin
        n_pc = r_pc;
        case (ctl.cond)
            rc4d_pkg::COND_NEXT: begin
                n_pc = r_pc + 1'b1;
            end
            rc4d_pkg::COND_ALWAYS: begin
                n_pc = ctl.target;
            end
            rc4d_pkg::COND_LOOP: begin
                n_pc = i_stat.cnt_last ? (r_pc + 1'b1) : ctl.target;
            end
            rc4d_pkg::COND_DISPATCH: begin
                if (i_stat.accept && i_stat.mode == rc4d_pkg::MODE_DATA) begin
                    n_pc = rc4d_pkg::PC_DAT_RD_I;
                end else if (i_stat.accept && i_stat.last) begin
                    n_pc = rc4d_pkg::PC_FILL;
                end
            end
            rc4d_pkg::COND_WAIT_OUT: begin
                if (i_stat.out_free) begin
                    n_pc = ctl.target;
                end
            end
            default: begin
                n_pc = rc4d_pkg::PC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rc4d_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    `RC4D_ASSERT(a_pc_range, r_pc <= rc4d_pkg::PC_LAST, "sequencer left the control store")
    `RC4D_ASSERT_NEXT(a_data_entry, i_stat.accept && i_stat.mode == rc4d_pkg::MODE_DATA, r_pc == rc4d_pkg::PC_DAT_RD_I, "data transfer did not start the cipher step")

endmodule

`default_nettype wire

// File: rtl/core/rc4d_dp.sv
// Datapath: permutation and key RAMs, pointers, key counter and loop counter,
// all driven by the microcode control word. Depends on rc4d_pkg, rc4d_ram.
`default_nettype none
`include "rc4_drop256_stream_cipher_unit_macros.svh"

module rc4d_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rc4d_pkg::t_ctl i_ctl,
    input  wire logic           i_key_wr,
    input  wire logic [7:0]     i_key_byte,
    output logic [7:0]          o_ks,
    output logic                o_cnt_last
);

    logic [7:0]                  r_i, n_i;
    logic [7:0]                  r_j, n_j;
    logic [7:0]                  r_k, n_k;
    logic [7:0]                  r_cnt;
    logic [7:0]                  r_si;
    logic [7:0]                  r_sj;
    logic [rc4d_pkg::KCNT_W-1:0] r_key_count;
    logic                        r_keyed;

    logic [7:0] s_addr, s_wdata, s_rdata, s_rd;
    logic [7:0] k_addr, k_rdata;
    logic       k_we;
    logic [rc4d_pkg::KCNT_W-1:0] k_plus;

    // Until the first schedule the table reads as all zeros.
    assign s_rd = r_keyed ? s_rdata : 8'd0;

    always_comb begin
        case (i_ctl.addr_sel)
            rc4d_pkg::ADDR_CNT:   s_addr = r_cnt;
            rc4d_pkg::ADDR_I:     s_addr = r_i;
            rc4d_pkg::ADDR_I_INC: s_addr = r_i + 8'd1;
            rc4d_pkg::ADDR_J:     s_addr = r_j;
            rc4d_pkg::ADDR_T:     s_addr = r_si + r_sj;
            default:              s_addr = r_i;
        endcase
        case (i_ctl.wd_sel)
            rc4d_pkg::WD_CNT: s_wdata = r_cnt;
            rc4d_pkg::WD_SI:  s_wdata = r_si;
            rc4d_pkg::WD_SJ:  s_wdata = r_sj;
            default:          s_wdata = r_si;
        endcase
    end

    rc4d_ram #(.DEPTH(rc4d_pkg::TABLE_DEPTH), .WIDTH(8)) u_perm (
        .i_clk   (i_clk),
        .i_we    (i_ctl.s_we),
        .i_addr  (s_addr),
        .i_wdata (s_wdata),
        .o_rdata (s_rdata)
    );

    // Key bytes past the store size are dropped.
    assign k_we   = i_key_wr && (r_key_count < rc4d_pkg::KEY_LIMIT);
    assign k_addr = k_we ? r_key_count[7:0] : r_k;

    rc4d_ram #(.DEPTH(rc4d_pkg::MAX_KEY_BYTES), .WIDTH(8)) u_key (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_addr  (k_addr),
        .i_wdata (i_key_byte),
        .o_rdata (k_rdata)
    );

    assign k_plus = {1'b0, r_k} + 9'd1;

    always_comb begin
        case (i_ctl.i_op)
            rc4d_pkg::I_INC: n_i = r_i + 8'd1;
            rc4d_pkg::I_CLR: n_i = 8'd0;
            default:         n_i = r_i;
        endcase
        case (i_ctl.j_op)
            rc4d_pkg::J_CLR:     n_j = 8'd0;
            rc4d_pkg::J_ADD_SI:  n_j = r_j + s_rd;
            rc4d_pkg::J_ADD_KEY: n_j = r_j + s_rd + k_rdata;
            default:             n_j = r_j;
        endcase
        case (i_ctl.k_op)
            rc4d_pkg::K_STEP: n_k = (k_plus >= r_key_count) ? 8'd0 : k_plus[7:0];
            rc4d_pkg::K_CLR:  n_k = 8'd0;
            default:          n_k = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= 8'd0;
            r_j         <= 8'd0;
            r_k         <= 8'd0;
            r_cnt       <= 8'd0;
            r_key_count <= '0;
            r_keyed     <= 1'b0;
        end else begin
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
            if (i_ctl.cnt_inc) begin
                r_cnt <= r_cnt + 8'd1;
            end
            if (i_ctl.clr_count) begin
                r_key_count <= '0;
            end else if (k_we) begin
                r_key_count <= r_key_count + 1'b1;
            end
            if (i_ctl.set_keyed) begin
                r_keyed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_si) begin
            r_si <= s_rd;
        end
        if (i_ctl.ld_sj) begin
            r_sj <= s_rd;
        end
    end

    assign o_ks       = s_rd;
    assign o_cnt_last = (r_cnt == rc4d_pkg::CNT_LAST);

    `RC4D_ASSERT(a_key_index, (r_key_count == '0) || ({1'b0, r_k} < r_key_count), "key index outside stored key")

endmodule

`default_nettype wire

// File: rtl/core/rc4_drop256_stream_cipher_unit.sv
// RC4 drop-256 stream cipher, top level: input handshake, data capture and
// output register. Depends on rc4d_pkg, rc4d_seq, rc4d_dp and the macro header.
//
// Usage: one byte per input transfer. Mode 0 transfers carry key bytes, with
// any nonce bytes sent straight after the key; the first 256 are stored.
// A key transfer with last set starts the key schedule (table fill over all
// 256 entries, 256 mixing rounds, one pointer clear, 256 discarded keystream
// rounds, one wrap-up step); o_in_ready stays low meanwhile. Other key
// transfers leave the unit idle with o_in_ready high.
// Mode 1 transfers carry data: o_out_byte is the byte XOR the next keystream
// byte and o_out_last copies last. o_in_ready stays low after a data
// transfer until its result is loaded into the output register, so no new
// byte is taken while one is being ciphered. The steps are set by the
// single-port permutation RAM: read S[i], read S[j], write both back, read
// S[S[i]+S[j]].
// The output register lets the next item be taken while a result waits; if
// the receiver still holds off when the next result is ready, the sequencer
// waits on its last step. Reset clears pointers and counters and makes the
// table read as all zeros, so data before any key passes unchanged.
`default_nettype none
`include "rc4_drop256_stream_cipher_unit_macros.svh"

module rc4_drop256_stream_cipher_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_mode,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    rc4d_pkg::t_ctl    ctl;
    rc4d_pkg::t_seq_in seq_in;
    logic              idle;
    logic              accept;
    logic              out_free;
    logic              cnt_last;
    logic [7:0]        ks;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_in_ready = idle && i_rst_n;
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign seq_in = '{
        accept:   accept,
        mode:     i_mode,
        last:     i_last,
        out_free: out_free,
        cnt_last: cnt_last
    };

    rc4d_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (seq_in),
        .o_ctl   (ctl),
        .o_idle  (idle)
    );

    rc4d_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_key_wr   (accept && i_mode == rc4d_pkg::MODE_KEY),
        .i_key_byte (i_byte_value),
        .o_ks       (ks),
        .o_cnt_last (cnt_last)
    );

    always_ff @(posedge i_clk) begin
        if (accept && i_mode == rc4d_pkg::MODE_DATA) begin
            r_byte <= i_byte_value;
            r_last <= i_last;
        end
        if (ctl.out_load && out_free) begin
            r_out_byte <= r_byte ^ ks;
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    `RC4D_ASSERT_NEXT(a_out_load, ctl.out_load && out_free, o_out_valid && idle, "lost result")

endmodule

`default_nettype wire

// File: tb/sv/rc4_cipher_checker.sv
`timescale 1ns / 100ps
// Checker for the RC4 drop-256 cipher: follows the key and data transfers,
// predicts every ciphered byte and compares it with the output channel.
// Depends on rc4d_pkg for the mode codes and the key store limit.

module rc4_cipher_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_byte_value,
    input  logic       i_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_err_count,
    output int         o_pending
);

    typedef struct {
        logic [7:0] ct_byte;
        logic       ct_last;
    } t_cipher_out;

    t_cipher_out                 cipher_out_q[$];
    logic [7:0]                  sbox [0:255];
    logic [7:0]                  key_mem [0:255];
    logic [rc4d_pkg::KCNT_W-1:0] key_len;
    logic [7:0]                  ptr_i;
    logic [7:0]                  ptr_j;
    int                          err_cnt = 0;

    function automatic logic [7:0] next_keystream();
        logic [7:0] t;
        logic [7:0] sum;
        ptr_i = ptr_i + 8'd1;
        ptr_j = ptr_j + sbox[ptr_i];
        t = sbox[ptr_i];
        sbox[ptr_i] = sbox[ptr_j];
        sbox[ptr_j] = t;
        sum = sbox[ptr_i] + sbox[ptr_j];
        return sbox[sum];
    endfunction

    // Key schedule over the stored bytes, then 256 discarded keystream bytes.
    function automatic void rekey();
        int         n;
        int         k;
        int         len;
        logic [7:0] j;
        logic [7:0] t;
        len = (key_len == 0) ? 1 : int'(key_len);
        for (n = 0; n < 256; n++)
            sbox[n] = n[7:0];
        j = 8'd0;
        k = 0;
        for (n = 0; n < 256; n++) begin
            j = j + sbox[n] + key_mem[k];
            t = sbox[n];
            sbox[n] = sbox[j];
            sbox[j] = t;
            k++;
            if (k >= len)
                k = 0;
        end
        ptr_i = 8'd0;
        ptr_j = 8'd0;
        for (n = 0; n < 256; n++)
            void'(next_keystream());
        key_len = '0;
    endfunction

    always @(posedge i_clk) begin : track
        t_cipher_out got;
        t_cipher_out want;
        if (!i_rst_n) begin
            for (int n = 0; n < 256; n++) begin
                sbox[n]    = 8'd0;
                key_mem[n] = 8'd0;
            end
            key_len = '0;
            ptr_i   = 8'd0;
            ptr_j   = 8'd0;
            cipher_out_q.delete();
        end else begin
            // Results leave before new inputs are folded in; a result never
            // belongs to an input taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                got.ct_byte = i_out_byte;
                got.ct_last = i_out_last;
                if (cipher_out_q.size() == 0) begin
                    $error("unexpected output transfer: out_byte=%02h out_last=%0b",
                           got.ct_byte, got.ct_last);
                    err_cnt++;
                end else begin
                    want = cipher_out_q.pop_front();
                    if (got.ct_byte !== want.ct_byte) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.ct_byte, got.ct_byte);
                        err_cnt++;
                    end
                    if (got.ct_last !== want.ct_last) begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.ct_last, got.ct_last);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode == rc4d_pkg::MODE_KEY) begin
                    if (key_len < rc4d_pkg::KEY_LIMIT) begin
                        key_mem[key_len[7:0]] = i_byte_value;
                        key_len = key_len + 1'b1;
                    end
                    if (i_last)
                        rekey();
                end else begin
                    want.ct_byte = i_byte_value ^ next_keystream();
                    want.ct_last = i_last;
                    cipher_out_q.push_back(want);
                end
            end
        end
        o_pending   <= cipher_out_q.size();
        o_err_count <= err_cnt;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the RC4 drop-256 cipher testbench: clock, reset, key and data
// stimulus, output back-pressure and the verdict. Uses rc4_cipher_checker.

module tb_top;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int TOTAL_ITEMS   = 500;
    localparam int SETTLE_CYCLES = 3000;   // longer than one key schedule

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_ready;
    logic       i_mode       = rc4d_pkg::MODE_KEY;
    logic [7:0] i_byte_value = 8'd0;
    logic       i_last       = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready  = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    int  err_count;
    int  pending;
    int  cycle_cnt  = 0;
    int  item_cnt   = 0;
    int  key_run    = 0;
    bit  no_gaps    = 1'b0;
    bit  long_hold  = 1'b0;

    always #10 i_clk = ~i_clk;

    rc4_drop256_stream_cipher_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_byte_value (i_byte_value),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last)
    );

    rc4_cipher_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_byte_value (i_byte_value),
        .i_last       (i_last),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_byte   (o_out_byte),
        .i_out_last   (o_out_last),
        .o_err_count  (err_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int send_gap();
        if (no_gaps || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    // Offers one item and holds it until the transfer; valid only drops when
    // an idle gap follows.
    task automatic send_item(input logic mode, input logic [7:0] value, input logic last);
        int gap;
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_byte_value <= value;
        i_last       <= last;
        do @(posedge i_clk); while (!o_in_ready);
        // Key bytes past the store size are dropped by the block; skip them in the tally.
        if (mode == rc4d_pkg::MODE_DATA) begin
            item_cnt++;
        end else begin
            if (key_run < rc4d_pkg::MAX_KEY_BYTES) begin
                item_cnt++;
                key_run++;
            end
            if (last)
                key_run = 0;
        end
        gap = send_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Key of the given length; optionally a data byte is slipped in midway.
    task automatic send_key(input int len, input bit data_inside);
        for (int n = 0; n < len; n++) begin
            if (data_inside && n == len / 2)
                send_item(rc4d_pkg::MODE_DATA, 8'($urandom), 1'($urandom));
            send_item(rc4d_pkg::MODE_KEY, 8'($urandom), n == len - 1);
        end
    endtask

    task automatic send_data(input int cnt);
        for (int n = 0; n < cnt; n++)
            send_item(rc4d_pkg::MODE_DATA, 8'($urandom),
                      (n == cnt - 1) || ($urandom_range(0, 15) == 0));
    endtask

    function automatic int key_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 16);
        else if (r < 95)
            return $urandom_range(17, 64);
        return $urandom_range(65, 256);
    endfunction

    // Output side: ready runs and idle gaps, plus one long hold-off on request.
    initial begin : out_side
        int run;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                i_out_ready <= 1'b0;
                repeat (500) @(posedge i_clk);
            end
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                              : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            i_out_ready <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    end

    initial begin : in_side
        int r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Data before any key passes through unchanged.
        send_item(rc4d_pkg::MODE_DATA, 8'h00, 1'b0);
        send_item(rc4d_pkg::MODE_DATA, 8'hFF, 1'b1);
        send_item(rc4d_pkg::MODE_DATA, 8'hA5, 1'b0);
        // Shortest key, all-zero byte.
        send_item(rc4d_pkg::MODE_KEY, 8'h00, 1'b1);
        send_item(rc4d_pkg::MODE_DATA, 8'hFF, 1'b0);
        send_item(rc4d_pkg::MODE_DATA, 8'h00, 1'b1);
        // Data inside a key sequence keeps the bytes collected so far.
        send_item(rc4d_pkg::MODE_KEY, 8'hFF, 1'b0);
        send_item(rc4d_pkg::MODE_KEY, 8'h80, 1'b0);
        send_item(rc4d_pkg::MODE_DATA, 8'h3C, 1'b1);
        send_item(rc4d_pkg::MODE_KEY, 8'h01, 1'b1);
        send_item(rc4d_pkg::MODE_DATA, 8'h5A, 1'b0);
        send_item(rc4d_pkg::MODE_DATA, 8'hC3, 1'b0);
        send_item(rc4d_pkg::MODE_DATA, 8'h7E, 1'b1);
        wait_results_drained();

        // Too many key bytes: the last mark sits past the store limit.
        send_key($urandom_range(rc4d_pkg::MAX_KEY_BYTES + 1, rc4d_pkg::MAX_KEY_BYTES + 40),
                 1'b0);
        send_data(4);

        // Receiver holds off while data keeps coming without gaps.
        long_hold = 1'b1;
        no_gaps   = 1'b1;
        send_data(40);
        no_gaps   = 1'b0;
        wait_results_drained();

        while (item_cnt < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 5) == 0);
            if (r < 55) begin
                send_key(key_length(), 1'b0);
                send_data($urandom_range(1, 20));
            end else if (r < 72) begin
                send_data($urandom_range(1, 20));
            end else if (r < 85) begin
                send_key($urandom_range(2, 24), 1'b1);
                send_data($urandom_range(1, 10));
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 1) == 0)
                        send_item(rc4d_pkg::MODE_KEY, 8'($urandom),
                                  $urandom_range(0, 7) == 0);
                    else
                        send_item(rc4d_pkg::MODE_DATA, 8'($urandom), 1'($urandom));
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_results_drained();
        end
        no_gaps = 1'b0;

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/rc4d_pkg.sv
rtl/core/rc4d_ram.sv
rtl/core/rc4d_seq.sv
rtl/core/rc4d_dp.sv
rtl/core/rc4_drop256_stream_cipher_unit.sv
tb/sv/rc4_cipher_checker.sv
tb/sv/tb_top.sv
